// File: src/cmfd_pkg.sv
// ============================================================================
// cmfd_pkg - shared types and constants of the frame deframer
// Frame geometry, result record and the marker sequence check.
// ============================================================================
package cmfd_pkg;

  localparam int FRAME_BYTES  = 5;
  localparam int WINDOW_BYTES = 2 * FRAME_BYTES;

  localparam logic [7:0]  MARKER_MAX_RESET = 8'd250;
  localparam logic [15:0] SAMPLE_OFFSET    = 16'h8000;

  localparam int PHASE_W = $clog2(FRAME_BYTES);
  localparam int FILL_W  = $clog2(WINDOW_BYTES + 1);

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(FRAME_BYTES - 1);
  localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(WINDOW_BYTES);

  typedef struct packed {
    logic [7:0]         frame_marker;
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
    logic [31:0]        frame_number;
  } frame_t;

  // next follows prev: plain increment (no 8-bit wrap) or wrap after marker_max
  function automatic logic follows(input logic [7:0] prev, input logic [7:0] next,
                                   input logic [7:0] mmax);
    logic inc;
    logic wrap;
    inc  = ({1'b0, next} == ({1'b0, prev} + 9'd1));
    wrap = (prev == mmax) && (next == 8'd0);
    return inc || wrap;
  endfunction

endpackage

// File: src/cmfd_byte_if.sv
// ============================================================================
// cmfd_byte_if - raw byte stream channel
// Valid/ready channel carrying one stream byte per transaction.
// ============================================================================
interface cmfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: src/cmfd_frame_if.sv
// ============================================================================
// cmfd_frame_if - decoded frame channel
// Valid/ready channel carrying one accepted frame per transaction.
// ============================================================================
interface cmfd_frame_if;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_marker;
  logic signed [15:0] sample_first;
  logic signed [15:0] sample_second;
  logic [31:0]        frame_number;

  modport source (output valid, output frame_marker, output sample_first,
                  output sample_second, output frame_number, input ready);
  modport sink   (input valid, input frame_marker, input sample_first,
                  input sample_second, input frame_number, output ready);
endinterface

// File: src/cmfd_cell.sv
// ============================================================================
// cmfd_cell - one byte cell of the window shift line
// Takes its din byte on every shift.
// ============================================================================
module cmfd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);
  logic [7:0] q;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  assign dout = q;
endmodule

// File: src/counter_marker_frame_deframer.sv
// ============================================================================
// counter_marker_frame_deframer - counter-marker frame deframer
// Recovers 5-byte frames (marker + two big-endian words) from a byte stream.
// ============================================================================
// Usage:
//   byte_in   : one raw stream byte per transaction (valid/ready).
//   frame_out : one transaction per accepted frame: marker, both samples
//               with 32768 taken off (signed), and the running frame count.
//   cfg_wen/cfg_wdata : write marker_max (largest marker before wrap to 0).
//               Write only while the block is idle.
// Throughput: one byte per cycle while the skid stage is free. The window is a row of ten
//   byte cells shifting on every accepted byte; the marker check is
//   combinational logic on two window taps and the incoming byte.
// Output: the byte that confirms the following marker (the next frame's
//   marker byte) registers the frame into out_reg, or skid_reg while frame_out stalls.
// Stall: results sit in an output register backed by a one-entry skid
//   stage, so bytes keep flowing while a result waits; byte_in.ready drops
//   only when both are full.
// Reset (rst, synchronous): unlocked, window fill count zero, frame count zero,
//   marker_max back to 250. After the first lock the phase is held for good;
//   frames that fail the marker check are skipped.
// ============================================================================
module counter_marker_frame_deframer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [7:0]           cfg_wdata,
  cmfd_byte_if.sink            byte_in,
  cmfd_frame_if.source         frame_out
);
  import cmfd_pkg::*;

  logic [7:0]         marker_max;
  logic [7:0]         win [WINDOW_BYTES];
  logic [FILL_W-1:0]  fill_count;
  logic               locked;
  logic [PHASE_W-1:0] phase;
  logic [31:0]        frames_seen;

  frame_t out_reg;
  frame_t skid_reg;
  logic   out_valid;
  logic   skid_valid;

  logic               byte_fire;
  logic               out_fire;
  logic [7:0]         b;
  logic [PHASE_W-1:0] phase_next;
  logic               sync_hit;
  logic               track_hit;
  logic               hit;
  frame_t             frame_next;

  assign b         = byte_in.data_byte;
  assign byte_fire = byte_in.valid && byte_in.ready;
  assign out_fire  = out_valid && frame_out.ready;

  // Window: oldest byte in cell 0, newest byte enters cell WINDOW_BYTES-1
  for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_win
    logic [7:0] din;
    if (i == WINDOW_BYTES - 1) begin : g_tail
      assign din = b;
    end else begin : g_body
      assign din = win[i+1];
    end
    cmfd_cell u_cell (
      .clk   (clk),
      .shift (byte_fire),
      .din   (din),
      .dout  (win[i])
    );
  end

  // Marker checks
  assign phase_next = (phase == PHASE_LAST) ? '0 : phase + PHASE_W'(1);
  assign sync_hit   = !locked && (fill_count == FILL_FULL) &&
                      follows(win[0], win[FRAME_BYTES], marker_max) &&
                      follows(win[FRAME_BYTES], b, marker_max);
  assign track_hit  = locked && (phase_next == '0) &&
                      follows(win[FRAME_BYTES], b, marker_max);
  assign hit        = byte_fire && (sync_hit || track_hit);

  // Frame lying in the upper half of the window
  always_comb begin
    frame_next.frame_marker  = win[FRAME_BYTES];
    frame_next.sample_first  = {win[FRAME_BYTES+1], win[FRAME_BYTES+2]} ^ SAMPLE_OFFSET;
    frame_next.sample_second = {win[FRAME_BYTES+3], win[FRAME_BYTES+4]} ^ SAMPLE_OFFSET;
    frame_next.frame_number  = frames_seen + 32'd1;
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_max <= MARKER_MAX_RESET;
    end else if (cfg_wen) begin
      marker_max <= cfg_wdata;
    end
  end

  // Sync / tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      locked      <= 1'b0;
      phase       <= '0;
      frames_seen <= '0;
    end else if (byte_fire) begin
      if (fill_count != FILL_FULL) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      if (sync_hit) begin
        locked <= 1'b1;
        phase  <= '0;
      end else if (locked) begin
        phase <= phase_next;
      end
      if (hit) begin
        frames_seen <= frames_seen + 32'd1;
      end
    end
  end

  // Output register plus skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (hit) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (hit) begin
      if (out_valid && !out_fire) begin
        skid_reg <= frame_next;
      end else begin
        out_reg <= frame_next;
      end
    end
  end

  assign byte_in.ready           = !skid_valid;
  assign frame_out.valid         = out_valid;
  assign frame_out.frame_marker  = out_reg.frame_marker;
  assign frame_out.sample_first  = out_reg.sample_first;
  assign frame_out.sample_second = out_reg.sample_second;
  assign frame_out.frame_number  = out_reg.frame_number;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a frame while output register is empty");

  a_lock_needs_window: assert property (@(posedge clk) disable iff (rst)
    locked |-> (fill_count == FILL_FULL))
    else $error("locked before the window was full");

  a_lock_sticky: assert property (@(posedge clk)
    (!rst && !$past(rst)) |-> !$fell(locked))
    else $error("lock lost without reset");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(hit)) |-> (frames_seen == $past(frames_seen) + 32'd1))
    else $error("frame count did not step on an accepted frame");

endmodule

// File: test/counter_marker_frame_deframer_tb.sv
// ============================================================================
// counter_marker_frame_deframer_tb - self-checking bench for the frame deframer
// Feeds counter-marker frames and noise through the byte channel and predicts
// every decoded frame. Random gaps are applied on both handshakes. The run
// steps through several marker_max settings while the block is idle.
// ============================================================================
`timescale 1ns / 1ps

module counter_marker_frame_deframer_tb;
  import cmfd_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;      // output stage is two entries deep, plenty of margin
  localparam int IDLE_LIMIT    = 50000;
  localparam int HOLD_CYCLES   = 300;    // long sink hold-off, fills the skid stage
  localparam int PHASE_BYTES   = 140;
  localparam int NUM_PHASES    = 8;
  localparam int MAX_REPORTS   = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  cmfd_byte_if  byte_ch ();
  cmfd_frame_if frame_ch ();

  counter_marker_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .byte_in   (byte_ch),
    .frame_out (frame_ch)
  );

  // --------------------------------------------------------------------------
  // Deframer prediction state: own copy of window, lock, phase and config
  // --------------------------------------------------------------------------
  logic [7:0]  win [WINDOW_BYTES];
  int          fill;
  bit          is_locked;
  int          frame_pos;
  logic [31:0] frames_emitted;
  logic [7:0]  marker_limit;

  frame_t      pending_frames [$];   // decoded frames still owed by the block
  logic [7:0]  stream_bytes [$];     // bytes waiting for the driver
  frame_t      want_frame;

  // Stimulus / handshake control
  int         gen_pos;               // bytes generated so far, marker at multiples of 5
  logic [7:0] next_marker;
  bit         no_idle = 1'b0;
  bit         hold_request = 1'b0;
  int         hold_left;
  int         send_gap;
  int         sink_gap;

  // Statistics
  int bytes_accepted = 0;
  int frames_checked = 0;
  int fail_count = 0;

  // nxt counts on from cur: plain +1 (never 255 -> 0) or wrap after marker_limit
  function automatic bit counts_on(input logic [7:0] cur, input logic [7:0] nxt);
    return ({1'b0, nxt} == ({1'b0, cur} + 9'd1)) ||
           ((cur == marker_limit) && (nxt == 8'd0));
  endfunction

  // One accepted byte through the predictor; queues a frame when one is due
  task automatic deframe_byte(input logic [7:0] b);
    frame_t f;
    bit     hit;
    hit = 1'b0;
    if (!is_locked) begin
      // sync search only with a full window: three markers one frame apart
      if (fill >= WINDOW_BYTES && counts_on(win[0], win[FRAME_BYTES]) &&
          counts_on(win[FRAME_BYTES], b)) begin
        is_locked = 1'b1;
        frame_pos = 0;
        hit       = 1'b1;
      end
    end else begin
      // locked for good: check on every marker slot, skip failing frames
      frame_pos = (frame_pos + 1) % FRAME_BYTES;
      hit = (frame_pos == 0) && counts_on(win[FRAME_BYTES], b);
    end
    if (hit) begin
      frames_emitted  = frames_emitted + 32'd1;
      f.frame_marker  = win[FRAME_BYTES];
      f.sample_first  = {win[FRAME_BYTES+1], win[FRAME_BYTES+2]} ^ SAMPLE_OFFSET;
      f.sample_second = {win[FRAME_BYTES+3], win[FRAME_BYTES+4]} ^ SAMPLE_OFFSET;
      f.frame_number  = frames_emitted;
      pending_frames.push_back(f);
    end
    for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] = win[i+1];
    win[WINDOW_BYTES-1] = b;
    if (fill < WINDOW_BYTES) fill++;
  endtask

  // Idle lengths: mostly zero or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample words, with the offset-binary extremes mixed in
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] marker_after(input logic [7:0] m);
    return (m == marker_limit) ? 8'd0 : m + 8'd1;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    gen_pos++;
  endtask

  task automatic push_frame(input logic [7:0] m, input logic [15:0] w1,
                            input logic [15:0] w2);
    push_byte(m);
    push_byte(w1[15:8]);
    push_byte(w1[7:0]);
    push_byte(w2[15:8]);
    push_byte(w2[7:0]);
  endtask

  // Block until the stream is drained and every owed frame has come back, or IDLE_LIMIT runs out
  task automatic wait_idle(input int settle);
    int n;
    n = 0;
    while ((stream_bytes.size() != 0 || byte_ch.valid || pending_frames.size() != 0 ||
            hold_left != 0) && n < IDLE_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (n >= IDLE_LIMIT) begin
      fail_count++;
      $display("ERROR: block stalled, %0d frames still owed", pending_frames.size());
    end
    repeat (settle) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Byte driver: pops the stream queue, random gap after every transaction.
  // valid gets one assignment per edge so back-to-back bytes never glitch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        deframe_byte(byte_ch.data_byte);
        bytes_accepted++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          byte_ch.valid <= 1'b0;
        end else if (stream_bytes.size() > 0) begin
          byte_ch.data_byte <= stream_bytes.pop_front();
          byte_ch.valid     <= 1'b1;
          send_gap          <= pick_gap();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long sink hold-off, counted here so the stimulus just pulses a request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Frame monitor: compares each transaction with the oldest owed frame,
  // and throttles ready at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
      sink_gap       <= 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (pending_frames.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: unexpected frame marker %0d number %0d",
                     frame_ch.frame_marker, frame_ch.frame_number);
        end else begin
          want_frame = pending_frames.pop_front();
          frames_checked++;
          if (want_frame.frame_marker  !== frame_ch.frame_marker  ||
              want_frame.sample_first  !== frame_ch.sample_first  ||
              want_frame.sample_second !== frame_ch.sample_second ||
              want_frame.frame_number  !== frame_ch.frame_number) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("ERROR: frame mismatch exp m=%0d s1=%0d s2=%0d n=%0d",
                       want_frame.frame_marker, want_frame.sample_first,
                       want_frame.sample_second, want_frame.frame_number,
                       " got m=%0d s1=%0d s2=%0d n=%0d",
                       frame_ch.frame_marker, frame_ch.sample_first,
                       frame_ch.sample_second, frame_ch.frame_number);
          end
        end
      end
      if (hold_left > 0) begin
        frame_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap       <= sink_gap - 1;
        frame_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        sink_gap       <= pick_gap();
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed lock sequence, then one random phase per setting
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] settings [NUM_PHASES];
    int         start_pos;
    int         r;
    int         n;

    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'd0;
    frame_ch.ready    = 1'b0;

    fill           = 0;
    is_locked      = 1'b0;
    frame_pos      = 0;
    frames_emitted = 32'd0;
    marker_limit   = MARKER_MAX_RESET;
    gen_pos        = 0;
    for (int i = 0; i < WINDOW_BYTES; i++) win[i] = 8'd0;

    // extremes first, two random mid values, 0 taken as written
    settings[0] = 8'd1;
    settings[1] = 8'd255;
    settings[2] = 8'd0;
    settings[3] = 8'($urandom_range(3, 249));
    settings[4] = 8'd250;
    settings[5] = 8'd2;
    settings[6] = 8'd254;
    settings[7] = 8'($urandom_range(3, 249));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, at reset marker_max 250:
    // 249,250,0 locks on the wrap and emits the 250 frame (sample extremes);
    // 255 breaks the chain and 255 -> 0 must not count as a plain increment;
    // 0 -> 1 then emits the mid-scale frame.
    push_frame(8'd249, 16'h1357, 16'h2468);
    push_frame(8'd250, 16'h0000, 16'hFFFF);
    push_frame(8'd0,   16'hA5A5, 16'h5A5A);
    push_frame(8'd255, 16'h1234, 16'h5678);
    push_frame(8'd0,   16'h8000, 16'h7FFF);
    push_frame(8'd1,   16'h7FFF, 16'h8000);
    wait_idle(SETTLE_CYCLES);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // block is idle here: write the new marker_max
      @(posedge clk);
      cfg_wen   <= 1'b1;
      cfg_wdata <= settings[p];
      @(posedge clk);
      cfg_wen <= 1'b0;
      @(negedge clk);
      marker_limit = settings[p];

      no_idle     = (p == 5);
      next_marker = 8'($urandom_range(0, marker_limit));
      start_pos   = gen_pos;

      // mostly clean frame runs, the rest corruption, noise and jumps
      while (gen_pos - start_pos < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            push_frame(next_marker, pick_word(), pick_word());
            next_marker = marker_after(next_marker);
          end
        end else if (r < 82) begin
          // corrupted marker, chain resumes after it
          push_frame(8'($urandom_range(0, 255)), pick_word(), pick_word());
          next_marker = marker_after(next_marker);
        end else if (r < 90) begin
          // noise burst, then pad back onto the locked frame phase
          n = $urandom_range(1, 12);
          repeat (n) push_byte(8'($urandom_range(0, 255)));
          while (gen_pos % FRAME_BYTES != 0) push_byte(8'($urandom_range(0, 255)));
        end else if (r < 95) begin
          next_marker = 8'($urandom_range(0, marker_limit));
        end else begin
          // dropped frame
          next_marker = marker_after(marker_after(next_marker));
        end
      end

      if (p == 3) begin
        // sink stalls while the driver keeps offering: input must back up
        hold_request = 1'b1;
        @(negedge clk);
        hold_request = 1'b0;
      end

      wait_idle(SETTLE_CYCLES);
    end

    if (pending_frames.size() != 0) begin
      fail_count += pending_frames.size();
      $display("ERROR: %0d frames never delivered", pending_frames.size());
    end

    $display("Checked %0d frames from %0d stream bytes over %0d marker_max settings",
             frames_checked, bytes_accepted, NUM_PHASES + 1);
    $display("Settings 0, 1, 250 and 255 included;",
             " one %0d-cycle sink hold-off and one gap-free phase", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
